// ===== hdl/id_allocator_swap_free_assert.svh =====
// assertion macros used by the id allocator datapath
// expects signals clk and arst_n in the scope where a macro is used
`ifndef ID_ALLOCATOR_SWAP_FREE_ASSERT_SVH
`define ID_ALLOCATOR_SWAP_FREE_ASSERT_SVH

// invariant checked on every clock edge out of reset
`define IDA_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition in one cycle implies a condition in the next
`define IDA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/idalloc_pkg.sv =====
// types, constants and command/status structs of the id allocator
// used by the controller, the datapath and the top level; no dependencies
package idalloc_pkg;

	localparam int CAPACITY = 64;
	localparam int ID_W = 6;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		RES_OK,
		RES_FULL,
		RES_NOT_FOUND,
		RES_FRESH,
		RES_REUSE
	} res_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_WAIT,
		S_SCAN,
		S_SWAP_WAIT,
		S_SWAP_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic take_in;
		logic res_set;
		res_kind_t res_kind;
		logic alloc_fresh;
		logic rd_live;
		logic live_inc;
		logic scan_start;
		logic scan_run;
		logic rd_last;
		logic wr_found;
		logic wr_last;
		logic clear;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic fresh;
		logic empty;
		logic hit;
		logic miss_end;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/idalloc_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module idalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/idalloc_ctrl.sv =====
// controller state machine of the id allocator
// depends on idalloc_pkg; drives datapath commands from datapath status
module idalloc_ctrl import idalloc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  mode_t in_mode,
	output logic  in_ready,
	input  sts_t  sts,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DONE;
					if (in_mode == MODE_ALLOC && !sts.full && !sts.fresh) begin
						state_d = S_ALLOC_WAIT;
					end else if (in_mode == MODE_FREE && !sts.empty) begin
						state_d = S_SCAN;
					end
				end
			end
			S_ALLOC_WAIT: state_d = S_DONE;
			S_SCAN: begin
				if (sts.hit) begin
					state_d = S_SWAP_WAIT;
				end else if (sts.miss_end) begin
					state_d = S_DONE;
				end
			end
			S_SWAP_WAIT: state_d = S_SWAP_WR;
			S_SWAP_WR: state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_kind = RES_OK;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					case (in_mode)
						MODE_ALLOC: begin
							if (sts.full) begin
								cmd.res_set = 1'b1;
								cmd.res_kind = RES_FULL;
							end else if (sts.fresh) begin
								cmd.alloc_fresh = 1'b1;
								cmd.res_set = 1'b1;
								cmd.res_kind = RES_FRESH;
							end else begin
								cmd.rd_live = 1'b1;
							end
						end
						MODE_FREE: begin
							if (sts.empty) begin
								cmd.res_set = 1'b1;
								cmd.res_kind = RES_NOT_FOUND;
							end else begin
								cmd.scan_start = 1'b1;
							end
						end
						MODE_CLEAR: begin
							cmd.clear = 1'b1;
							cmd.res_set = 1'b1;
						end
						default: cmd.res_set = 1'b1;
					endcase
				end
			end
			S_ALLOC_WAIT: begin
				cmd.live_inc = 1'b1;
				cmd.res_set = 1'b1;
				cmd.res_kind = RES_REUSE;
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.rd_last = 1'b1;
				end else if (sts.miss_end) begin
					cmd.res_set = 1'b1;
					cmd.res_kind = RES_NOT_FOUND;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			S_SWAP_WAIT: cmd.wr_found = 1'b1;
			S_SWAP_WR: begin
				cmd.wr_last = 1'b1;
				cmd.res_set = 1'b1;
			end
			S_DONE: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/idalloc_dp.sv =====
// datapath of the id allocator: counters, slot table, scan pipeline, result regs
// depends on idalloc_pkg, idalloc_ram and the assertion macro header
`include "id_allocator_swap_free_assert.svh"

module idalloc_dp import idalloc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [ID_W-1:0] in_id,
	input  cmd_t            cmd,
	output sts_t            sts,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [ID_W-1:0] out_given_id,
	output status_t         out_status
);

	logic [CNT_W-1:0] live_q, hw_q, idx_q;
	logic [ID_W-1:0]  id_q;
	logic [IDX_W-1:0] found_q, idx_s1, last_idx;
	logic             vld_s1;
	logic [ID_W-1:0]  res_given_q, out_given_q;
	status_t          res_status_q, out_status_q;
	logic             out_valid_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [ID_W-1:0]  ram_wdata, ram_rdata;
	logic             issue_ok, hit;

	assign last_idx = IDX_W'(live_q - CNT_W'(1));
	assign issue_ok = idx_q < live_q;
	assign hit = vld_s1 && (ram_rdata == id_q);

	assign sts.full = live_q == CNT_W'(CAPACITY);
	assign sts.fresh = live_q == hw_q;
	assign sts.empty = live_q == '0;
	assign sts.hit = hit;
	assign sts.miss_end = vld_s1 && !hit && (idx_s1 == last_idx);
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		ram_raddr = idx_q[IDX_W-1:0];
		if (cmd.rd_live) begin
			ram_raddr = live_q[IDX_W-1:0];
		end else if (cmd.rd_last) begin
			ram_raddr = last_idx;
		end
	end

	always_comb begin
		ram_we = cmd.alloc_fresh || cmd.wr_found || cmd.wr_last;
		ram_waddr = last_idx;
		ram_wdata = id_q;
		if (cmd.alloc_fresh) begin
			ram_waddr = live_q[IDX_W-1:0];
			ram_wdata = hw_q[ID_W-1:0];
		end else if (cmd.wr_found) begin
			ram_waddr = found_q;
			ram_wdata = ram_rdata;
		end
	end

	idalloc_ram #(
		.WIDTH(ID_W),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			hw_q <= '0;
		end else if (cmd.clear) begin
			live_q <= '0;
			hw_q <= '0;
		end else if (cmd.alloc_fresh) begin
			live_q <= live_q + CNT_W'(1);
			hw_q <= hw_q + CNT_W'(1);
		end else if (cmd.live_inc) begin
			live_q <= live_q + CNT_W'(1);
		end else if (cmd.wr_last) begin
			live_q <= live_q - CNT_W'(1);
		end
	end

	// scan pipeline: read issued one cycle, compared the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			idx_q <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.scan_run) begin
			idx_q <= idx_q + CNT_W'(1);
			vld_s1 <= issue_ok;
		end else begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			id_q <= in_id;
		end
		if (cmd.scan_run) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (cmd.rd_last) begin
			found_q <= idx_s1;
		end
		if (cmd.res_set) begin
			case (cmd.res_kind)
				RES_FULL: begin
					res_given_q <= '0;
					res_status_q <= ST_FULL;
				end
				RES_NOT_FOUND: begin
					res_given_q <= '0;
					res_status_q <= ST_NOT_FOUND;
				end
				RES_FRESH: begin
					res_given_q <= hw_q[ID_W-1:0];
					res_status_q <= ST_OK;
				end
				RES_REUSE: begin
					res_given_q <= ram_rdata;
					res_status_q <= ST_OK;
				end
				default: begin
					res_given_q <= '0;
					res_status_q <= ST_OK;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_given_q <= res_given_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_given_id = out_given_q;
	assign out_status = out_status_q;

	`IDA_ASSERT(a_live_le_hw, live_q <= hw_q, "live count above high water")
	`IDA_ASSERT(a_hw_le_cap, hw_q <= CNT_W'(CAPACITY), "high water beyond capacity")
	`IDA_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid_q, "result beat not presented")
	`IDA_ASSERT_NEXT(a_free_shrinks, cmd.wr_last, live_q == $past(live_q) - CNT_W'(1), "free did not shrink live count")

endmodule

// ===== hdl/id_allocator_swap_free.sv =====
// id allocator with swap-on-free slot table: streaming in, one result beat out
// channels: s_* carries an operation (mode, id), m_* carries (given_id, status)
// every accepted input beat produces exactly one output beat, in order
// steps from the input accept to the result beat: an allocate of a fresh id goes
// straight to S_DONE, one that reuses a freed id first passes S_ALLOC_WAIT (one
// slot table read); clear, no-op, allocate when full and free on an empty table
// go straight to S_DONE; free: the scan reads one slot table entry per cycle
// through the single read port and stops at the match, then one read and two
// writes swap the entry with the last live one; a miss ends at the last live entry
// one operation is in flight at a time; s_tready is high only while idle, so a new
// operation is not accepted until the last one has left S_DONE
// the result sits in an output register; a new operation is accepted while it
// waits, and the next result waits in the block until m_tready takes the beat
// reset: live count and high water go to zero, no output beat pending; the slot
// table needs no clearing since entries are only read after being written
// depends on idalloc_pkg, idalloc_ctrl, idalloc_dp
module id_allocator_swap_free import idalloc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // mode [1:0], id [7:2]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // given_id [5:0], status [7:6]
);

	cmd_t            cmd;
	sts_t            sts;
	logic [ID_W-1:0] given_id;
	status_t         status;

	idalloc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_mode (mode_t'(s_tdata[1:0])),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	idalloc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_id       (s_tdata[7:2]),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_given_id(given_id),
		.out_status  (status)
	);

	assign m_tdata = {status, given_id};

endmodule
